@@ design/grqb_pkg.sv @@
package grqb_pkg;

  localparam int QUEUE_DEPTH_DEF  = 1024;
  localparam int TASK_ID_BITS_DEF = 16;

  localparam int ID_W     = 16;
  localparam int ACTION_W = 2;
  localparam int LIMIT_W  = 8;
  localparam int PROCS_W  = 9;
  localparam int CAP_W    = 8;
  localparam int QCOUNT_W = 11;

  // largest batch and the width that holds it
  localparam int MAX_BATCH = 64;
  localparam int BATCH_W   = 7;

  localparam logic [ACTION_W-1:0] ACT_PUT_TAIL = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUT_HEAD = 2'd1;

  localparam logic CFG_NUM_PROCS = 1'b0;
  localparam logic CFG_LOCAL_CAP = 1'b1;

  localparam logic [PROCS_W-1:0] NUM_PROCS_RST = 9'd1;
  localparam logic [CAP_W-1:0]   LOCAL_CAP_RST = 8'd64;

  typedef enum logic [1:0] {
    OP_PUT_TAIL,
    OP_PUT_HEAD,
    OP_GET
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   task_id;
    logic [LIMIT_W-1:0] limit;
  } cmd_t;

  typedef struct packed {
    logic [PROCS_W-1:0] num_procs;
    logic [CAP_W-1:0]   local_cap;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ONE,
    BK_DIV,
    BK_SIZE,
    BK_RD,
    BK_OUT
  } bk_state_t;

endpackage

@@ design/grqb_in_if.sv @@
interface grqb_in_if;
  logic                              valid;
  logic                              ready;
  logic [grqb_pkg::ACTION_W-1:0]     action;
  logic [grqb_pkg::ID_W-1:0]         task_id;
  logic [grqb_pkg::LIMIT_W-1:0]      batch_limit;

  modport source (output valid, action, task_id, batch_limit, input ready);
  modport sink   (input valid, action, task_id, batch_limit, output ready);
endinterface

@@ design/grqb_out_if.sv @@
interface grqb_out_if;
  logic                              valid;
  logic                              ready;
  logic [grqb_pkg::ID_W-1:0]         task_out;
  logic                              found;
  logic                              to_local;
  logic                              dropped;
  logic                              last;
  logic [grqb_pkg::QCOUNT_W-1:0]     queue_count;

  modport source (output valid, task_out, found, to_local, dropped, last, queue_count,
                  input ready);
  modport sink   (input valid, task_out, found, to_local, dropped, last, queue_count,
                  output ready);
endinterface

@@ design/grqb_front.sv @@
module grqb_front (
  input  logic              clk,
  input  logic              rst_n,
  grqb_in_if.sink           in_ch,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output grqb_pkg::cmd_t    cmd
);

  logic           v_r, v_nxt;
  grqb_pkg::cmd_t cmd_r, cmd_nxt;
  logic           accept;

  assign in_ch.ready = !v_r || cmd_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd_valid   = v_r;
  assign cmd         = cmd_r;

  always_comb begin
    v_nxt   = v_r;
    cmd_nxt = cmd_r;
    if (accept) begin
      v_nxt           = 1'b1;
      cmd_nxt.task_id = in_ch.task_id;
      cmd_nxt.limit   = in_ch.batch_limit;
      // actions 2 and 3 fall through to a batch get
      unique case (in_ch.action)
        grqb_pkg::ACT_PUT_TAIL: cmd_nxt.op = grqb_pkg::OP_PUT_TAIL;
        grqb_pkg::ACT_PUT_HEAD: cmd_nxt.op = grqb_pkg::OP_PUT_HEAD;
        default:                cmd_nxt.op = grqb_pkg::OP_GET;
      endcase
    end else if (cmd_ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

@@ design/grqb_cmdq.sv @@
module grqb_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  grqb_pkg::cmd_t    push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output grqb_pkg::cmd_t    pop_data
);

  grqb_pkg::cmd_t ent_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) ent_r[wp_r] <= push_data;
  end

endmodule

@@ design/grqb_div.sv @@
module grqb_div #(
  parameter int W = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [W-1:0]                 dividend,
  input  logic [grqb_pkg::PROCS_W-1:0] divisor,
  output logic                         done,
  output logic [W-1:0]                 quot
);

  localparam int CNT_W = $clog2(W + 1);
  localparam int PW    = grqb_pkg::PROCS_W;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]    rem_r, rem_nxt;
  logic [PW-1:0]    div_r, div_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [PW:0]      trial, diff;
  logic             ge;

  // restoring division, one quotient bit a cycle; dividend bits shift out
  // of quo_r as quotient bits shift in
  assign trial = {rem_r, quo_r[W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};
  assign done  = done_r;
  assign quot  = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      div_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[PW-1:0] : trial[PW-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

endmodule

@@ design/grqb_back.sv @@
module grqb_back #(
  parameter int QUEUE_DEPTH  = grqb_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = grqb_pkg::TASK_ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  grqb_pkg::cfg_t    cfg,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  grqb_pkg::cmd_t    cmd,
  grqb_out_if.source        out_ch
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int BW = grqb_pkg::BATCH_W;

  grqb_pkg::bk_state_t state_r, state_nxt;

  logic [AW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic                        drop_r, drop_nxt;
  logic [grqb_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic [CW-1:0]               q_r, q_nxt;
  logic [BW-1:0]               rem_r, rem_nxt;
  logic                        first_r, first_nxt;

  logic                        ov_r, ov_nxt;
  logic [grqb_pkg::ID_W-1:0]   otask_r, otask_nxt;
  logic                        ofound_r, ofound_nxt;
  logic                        olocal_r, olocal_nxt;
  logic                        odrop_r, odrop_nxt;
  logic                        olast_r, olast_nxt;
  logic [grqb_pkg::QCOUNT_W-1:0] ocount_r, ocount_nxt;

  logic [TASK_ID_BITS-1:0]     mem [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0]     rd_data_r;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [TASK_ID_BITS-1:0]     mem_wdata;

  logic                        div_start, div_done;
  logic [CW-1:0]               div_quot;
  logic [grqb_pkg::PROCS_W-1:0] procs;

  logic [CW:0]                 tsum;
  logic [AW-1:0]               tail_addr, head_dec, head_inc;
  logic [31:0]                 task_wide, rd_wide, count_wide, q_wide, cnt_after_wide;
  logic [BW-1:0]               n_q, n_m, half;
  logic                        out_free;

  assign procs = (cfg.num_procs == '0) ? grqb_pkg::PROCS_W'(1) : cfg.num_procs;

  grqb_div #(.W(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (count_r),
    .divisor  (procs),
    .done     (div_done),
    .quot     (div_quot)
  );

  // ring arithmetic, depth need not be a power of two
  always_comb begin
    tsum = (CW + 1)'(head_r) + (CW + 1)'(count_r);
    if (tsum >= (CW + 1)'(QUEUE_DEPTH)) tsum = tsum - (CW + 1)'(QUEUE_DEPTH);
    tail_addr = tsum[AW-1:0];
    head_dec  = (head_r == '0) ? AW'(QUEUE_DEPTH - 1) : head_r - 1'b1;
    head_inc  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  end

  // batch size: min(q+1, 64, limit if nonzero, capacity/2, count), at least one
  always_comb begin
    q_wide     = 32'(q_r);
    count_wide = 32'(count_r);
    half       = BW'(cfg.local_cap >> 1);
    n_q = (q_wide >= 32'(grqb_pkg::MAX_BATCH)) ? BW'(grqb_pkg::MAX_BATCH)
                                               : q_wide[BW-1:0] + 1'b1;
    n_m = n_q;
    if (limit_r != '0 && 32'(limit_r) < 32'(n_m)) n_m = limit_r[BW-1:0];
    if (half < n_m) n_m = half;
    if (count_wide < 32'(n_m)) n_m = count_wide[BW-1:0];
    if (n_m == '0) n_m = BW'(1);
  end

  assign task_wide      = 32'(cmd.task_id);
  assign rd_wide        = 32'(rd_data_r);
  assign cnt_after_wide = 32'(count_r);
  assign out_free       = !ov_r || out_ch.ready;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    drop_nxt   = drop_r;
    limit_nxt  = limit_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    first_nxt  = first_r;
    ov_nxt     = ov_r;
    otask_nxt  = otask_r;
    ofound_nxt = ofound_r;
    olocal_nxt = olocal_r;
    odrop_nxt  = odrop_r;
    olast_nxt  = olast_r;
    ocount_nxt = ocount_r;
    cmd_ready  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = tail_addr;
    mem_wdata  = task_wide[TASK_ID_BITS-1:0];
    div_start  = 1'b0;

    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    unique case (state_r)
      grqb_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_ready = 1'b1;
          drop_nxt  = 1'b0;
          if (cmd.op == grqb_pkg::OP_GET) begin
            if (count_r == '0) begin
              state_nxt = grqb_pkg::BK_ONE;
            end else begin
              limit_nxt = cmd.limit;
              div_start = 1'b1;
              state_nxt = grqb_pkg::BK_DIV;
            end
          end else if (count_r == CW'(QUEUE_DEPTH)) begin
            drop_nxt  = 1'b1;
            state_nxt = grqb_pkg::BK_ONE;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
            if (cmd.op == grqb_pkg::OP_PUT_HEAD) begin
              mem_waddr = head_dec;
              head_nxt  = head_dec;
            end
            state_nxt = grqb_pkg::BK_ONE;
          end
        end
      end
      grqb_pkg::BK_ONE: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          otask_nxt  = '0;
          ofound_nxt = 1'b0;
          olocal_nxt = 1'b0;
          odrop_nxt  = drop_r;
          olast_nxt  = 1'b1;
          ocount_nxt = cnt_after_wide[grqb_pkg::QCOUNT_W-1:0];
          state_nxt  = grqb_pkg::BK_IDLE;
        end
      end
      grqb_pkg::BK_DIV: begin
        if (div_done) begin
          q_nxt     = div_quot;
          state_nxt = grqb_pkg::BK_SIZE;
        end
      end
      grqb_pkg::BK_SIZE: begin
        count_nxt = count_r - CW'(n_m);
        rem_nxt   = n_m;
        first_nxt = 1'b1;
        state_nxt = grqb_pkg::BK_RD;
      end
      grqb_pkg::BK_RD: begin
        // store read of the head entry lands in rd_data_r
        state_nxt = grqb_pkg::BK_OUT;
      end
      grqb_pkg::BK_OUT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          otask_nxt  = rd_wide[grqb_pkg::ID_W-1:0];
          ofound_nxt = 1'b1;
          olocal_nxt = !first_r;
          odrop_nxt  = 1'b0;
          olast_nxt  = (rem_r == BW'(1));
          ocount_nxt = cnt_after_wide[grqb_pkg::QCOUNT_W-1:0];
          head_nxt   = head_inc;
          rem_nxt    = rem_r - 1'b1;
          first_nxt  = 1'b0;
          state_nxt  = (rem_r == BW'(1)) ? grqb_pkg::BK_IDLE : grqb_pkg::BK_RD;
        end
      end
      default: state_nxt = grqb_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grqb_pkg::BK_IDLE;
      head_r  <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
    drop_r   <= drop_nxt;
    limit_r  <= limit_nxt;
    q_r      <= q_nxt;
    rem_r    <= rem_nxt;
    first_r  <= first_nxt;
    otask_r  <= otask_nxt;
    ofound_r <= ofound_nxt;
    olocal_r <= olocal_nxt;
    odrop_r  <= odrop_nxt;
    olast_r  <= olast_nxt;
    ocount_r <= ocount_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[head_r];
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.task_out    = otask_r;
  assign out_ch.found       = ofound_r;
  assign out_ch.to_local    = olocal_r;
  assign out_ch.dropped     = odrop_r;
  assign out_ch.last        = olast_r;
  assign out_ch.queue_count = ocount_r;

endmodule

@@ design/global_run_queue_batch.sv @@
// Path: commands pass the front register and the two-entry command queue to the back
//   end. A put (dropped when full) or an empty get gives one result; other gets size
//   the batch with a divider on the task count (CW bits, 11 at depth 1024, one quotient
//   bit a cycle), then give one result per store read, held while the output stalls.
// Flow: the back end takes one item at a time; front and queue accept up to 3 ahead.
// Reset: synchronous, active low; clears pointers, counts and valids. Store contents
//   stay undefined and are never read before being written.
module global_run_queue_batch #(
  parameter int QUEUE_DEPTH  = grqb_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = grqb_pkg::TASK_ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  grqb_in_if.sink                      in_ch,
  grqb_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [grqb_pkg::PROCS_W-1:0] cfg_wdata
);

  logic [grqb_pkg::PROCS_W-1:0] num_procs_r;
  logic [grqb_pkg::CAP_W-1:0]   local_cap_r;
  grqb_pkg::cfg_t               cfg;

  logic           f_valid, f_ready;
  grqb_pkg::cmd_t f_cmd;
  logic           q_valid, q_ready;
  grqb_pkg::cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_procs_r <= grqb_pkg::NUM_PROCS_RST;
      local_cap_r <= grqb_pkg::LOCAL_CAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        grqb_pkg::CFG_NUM_PROCS: num_procs_r <= cfg_wdata;
        grqb_pkg::CFG_LOCAL_CAP: local_cap_r <= cfg_wdata[grqb_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.num_procs = num_procs_r;
  assign cfg.local_cap = local_cap_r;

  grqb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  grqb_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  grqb_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // results without a task are single: put results and the empty get
  a_notfound_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.last && !out_ch.to_local))
    else $error("result without task is not a lone final result");

  a_local_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.to_local || out_ch.dropped)) |->
    (out_ch.found != out_ch.dropped))
    else $error("dropped and found flags disagree");

  // the front holds its command steady while the queue is full
  a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && !f_ready) |=> (f_valid && f_cmd == $past(f_cmd)))
    else $error("front command changed while the queue was full");
`endif

endmodule
